@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/msps_pkg.sv @@
// Package for the m-sequence product shift search block.
// Field widths, codes, defaults and the controller state type; no dependencies.
`timescale 1ns / 1ps

package msps_pkg;

    localparam int MAX_ORDER_DEF = 10;
    localparam int ORDER_W       = 4;
    localparam int STATE_W       = 10;
    localparam int IDX_W         = 10;
    localparam int SHIFT_W       = 11;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

    // item mode codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } ctrl_state_t;

endpackage

@@ design/msps_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module msps_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/msps_shift_wrap.sv @@
// Shift wrap unit: adds (len - 1) once to a negative shift and range checks it.
// Depends on msps_pkg.
`timescale 1ns / 1ps

module msps_shift_wrap
    import msps_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic signed [SHIFT_W-1:0] shift,
    input  logic [MAX_ORDER:0]        len,
    output logic [MAX_ORDER-1:0]      pos,
    output logic                      bad
);

    localparam int SW = (MAX_ORDER + 2 > SHIFT_W + 1) ? MAX_ORDER + 2 : SHIFT_W + 1;

    logic signed [SW-1:0] shift_ext;
    logic signed [SW-1:0] len_ext;
    logic signed [SW-1:0] wrapped;

    assign shift_ext = SW'(shift);
    assign len_ext   = signed'(SW'(len));

    // single wrap, then range check against the table size
    always_comb
    begin
        if (shift_ext < 0)
        begin
            wrapped = shift_ext + len_ext - SW'(1);
        end
        else
        begin
            wrapped = shift_ext;
        end
    end

    assign bad = (wrapped < 0) || (wrapped >= len_ext);
    assign pos = wrapped[MAX_ORDER-1:0];

endmodule

@@ design/msps_ctrl.sv @@
// Controller and datapath: table RAM, clearing pass, loads, lookups and scan.
// Depends on msps_pkg and msps_ram.
`timescale 1ns / 1ps

module msps_ctrl
    import msps_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 mode,
    input  logic [IDX_W-1:0]     load_index,
    input  logic [STATE_W-1:0]   load_value,
    input  logic [MAX_ORDER-1:0] pos_a,
    input  logic [MAX_ORDER-1:0] pos_b,
    input  logic                 shift_bad,
    input  logic [MAX_ORDER-1:0] len_m1,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [IDX_W-1:0]     found_index,
    output logic                 found,
    output logic                 bad_shift
);

    localparam int AW    = MAX_ORDER;
    localparam int DEPTH = 1 << MAX_ORDER;

    ctrl_state_t state_reg, state_next;

    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      pa_reg;
    logic [AW-1:0]      pb_reg;
    logic               bad_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic               cmp_vld_reg;
    logic               first_reg;
    logic [STATE_W-1:0] a_reg;
    logic [STATE_W-1:0] target_reg;
    logic               hit_reg;
    logic [AW-1:0]      hit_idx_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_found_reg;
    logic               out_bad_reg;

    logic               accept;
    logic               out_free;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [STATE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [STATE_W-1:0] ram_rdata;

    assign accept   = item_valid && !item_stall;
    assign out_free = !out_valid_reg || !result_stall;

    msps_ram #(
        .WIDTH (STATE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && mode == MODE_QUERY)
                begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                state_next = bad_reg ? ST_DONE : ST_RD_B;
            end
            ST_RD_B:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == len_m1)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs: input stall and RAM port control
    always_comb
    begin
        item_stall = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = clr_reg;
        ram_wdata  = '0;
        ram_raddr  = '0;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                item_stall = 1'b0;
                ram_we     = item_valid && mode == MODE_LOAD;
                ram_waddr  = AW'(load_index);
                ram_wdata  = load_value;
            end
            ST_RD_A:
            begin
                ram_raddr = pa_reg;
            end
            ST_RD_B:
            begin
                ram_raddr = pb_reg;
            end
            ST_SCAN:
            begin
                ram_raddr = idx_reg;
            end
            ST_LAST, ST_DONE:
            begin
                ram_raddr = '0;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            first_reg   <= (state_reg == ST_RD_B);
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && mode == MODE_QUERY)
        begin
            pa_reg      <= pos_a;
            pb_reg      <= pos_b;
            bad_reg     <= shift_bad;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
        end
        if (state_reg == ST_RD_B)
        begin
            a_reg <= ram_rdata;
        end
        if (state_reg == ST_SCAN)
        begin
            idx_reg     <= idx_reg + AW'(1);
            cmp_idx_reg <= idx_reg;
            if (first_reg)
            begin
                target_reg <= a_reg ^ ram_rdata;
            end
        end
        // compare the entry read in the previous cycle; later hits override
        if (cmp_vld_reg && ram_rdata == target_reg)
        begin
            hit_reg     <= 1'b1;
            hit_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_idx_reg   <= IDX_W'(hit_idx_reg);
            out_found_reg <= hit_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign found_index  = out_idx_reg;
    assign found        = out_found_reg;
    assign bad_shift    = out_bad_reg;

endmodule

@@ design/msequence_product_shift_search_top.sv @@
// M-sequence product shift search, top level.
// Config register, order clamp, shift wrap units and controller.
// Depends on msps_pkg, msps_shift_wrap and msps_ctrl (with msps_ram).
//
// Usage:
//   Item channel (item_valid / item_stall): mode 0 writes load_value into the
//   state table at load_index; mode 1 queries shift_a, shift_b.
//   Result channel (result_valid / result_stall): one word per query with
//   found_index, found and bad_shift; loads give no word.
//   Config channel (cfg_valid / cfg_ready): cfg_data sets the register order
//   n; ready is always high. Write it only while the block is idle.
//   A query reads both states, then scans all 2^n entries one per RAM read
//   cycle, passing RD_A, RD_B, SCAN, LAST and DONE before the result is
//   registered; no new item is taken until the controller returns to idle.
//   A shift out of range goes from RD_A straight to DONE, skipping the scan.
//   The single RAM port sets the scan rate.
//   After reset the table is cleared in a pass over all 2^MAX_ORDER entries
//   (1024 by default) with item_stall high; the order resets to 10.
//   A result waits in the output register while result_stall is high; the
//   next item may be taken meanwhile, but a query holds in its last state
//   until the output register is free.
`timescale 1ns / 1ps

module msequence_product_shift_search_top
    import msps_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ORDER_W-1:0]        cfg_data,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic                      mode,
    input  logic [IDX_W-1:0]          load_index,
    input  logic [STATE_W-1:0]        load_value,
    input  logic signed [SHIFT_W-1:0] shift_a,
    input  logic signed [SHIFT_W-1:0] shift_b,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [IDX_W-1:0]          found_index,
    output logic                      found,
    output logic                      bad_shift
);

    localparam int AW = MAX_ORDER;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int CW = (OW > ORDER_W) ? OW : ORDER_W;

    logic [ORDER_W-1:0] order_reg;
    logic [CW-1:0]      order_raw;
    logic [CW-1:0]      order_clamp;
    logic [OW-1:0]      order_eff;
    logic [AW:0]        len;
    logic [AW-1:0]      len_m1;
    logic [AW-1:0]      pos_a;
    logic [AW-1:0]      pos_b;
    logic               bad_a;
    logic               bad_b;

    assign cfg_ready = 1'b1;

    // order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            order_reg <= cfg_data;
        end
    end

    // clamp order to 1 .. MAX_ORDER and form the table size
    assign order_raw = CW'(order_reg);

    always_comb
    begin
        if (order_raw == '0)
        begin
            order_clamp = CW'(1);
        end
        else if (order_raw > CW'(MAX_ORDER))
        begin
            order_clamp = CW'(MAX_ORDER);
        end
        else
        begin
            order_clamp = order_raw;
        end
    end

    assign order_eff = OW'(order_clamp);
    assign len       = (AW + 1)'(1) << order_eff;
    assign len_m1    = AW'(len - (AW + 1)'(1));

    msps_shift_wrap #(
        .MAX_ORDER (MAX_ORDER)
    ) u_wrap_a (
        .shift (shift_a),
        .len   (len),
        .pos   (pos_a),
        .bad   (bad_a)
    );

    msps_shift_wrap #(
        .MAX_ORDER (MAX_ORDER)
    ) u_wrap_b (
        .shift (shift_b),
        .len   (len),
        .pos   (pos_b),
        .bad   (bad_b)
    );

    msps_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .load_index   (load_index),
        .load_value   (load_value),
        .pos_a        (pos_a),
        .pos_b        (pos_b),
        .shift_bad    (bad_a || bad_b),
        .len_m1       (len_m1),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found_index  (found_index),
        .found        (found),
        .bad_shift    (bad_shift)
    );

endmodule

@@ design/msps_checker.sv @@
// Port-level checker for the search block, bound to the top level.
// Depends on msps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msps_checker
    import msps_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             mode,
    input logic             result_valid,
    input logic             result_stall,
    input logic [IDX_W-1:0] found_index,
    input logic             found,
    input logic             bad_shift
);

    // a waiting word stays offered
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, result_valid && result_stall, result_valid)

    // no match means index zero
    `ASSERT_IMPL(a_miss_zero, clk, rst_n, result_valid && !found, found_index == '0)

    // a bad shift is never a hit
    `ASSERT_IMPL(a_bad_no_hit, clk, rst_n, result_valid && bad_shift, !found)

    // a load on an empty output gives no word
    `ASSERT_NEXT(a_load_silent, clk, rst_n,
        item_valid && !item_stall && mode == MODE_LOAD && !result_valid, !result_valid)

    // a query keeps the block busy the next cycle
    `ASSERT_NEXT(a_query_busy, clk, rst_n,
        item_valid && !item_stall && mode == MODE_QUERY, item_stall)

endmodule

bind msequence_product_shift_search_top msps_checker u_checker (.*);

@@ tb/sv/msequence_product_shift_search_top_test.sv @@
// Self-checking testbench for msequence_product_shift_search_top.
// Mirrors the state table and order register to predict every search word.
// Depends on msps_pkg and the block's RTL only.
`timescale 1ns / 1ps

module msequence_product_shift_search_top_test;
    import msps_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TABLE_DEPTH    = 1 << MAX_ORDER_DEF;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             hit;
        logic             bad;
    } search_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [ORDER_W-1:0]        cfg_data;
    logic                      item_valid;
    logic                      item_stall;
    logic                      mode;
    logic [IDX_W-1:0]          load_index;
    logic [STATE_W-1:0]        load_value;
    logic signed [SHIFT_W-1:0] shift_a;
    logic signed [SHIFT_W-1:0] shift_b;
    logic                      result_valid;
    logic                      result_stall;
    logic [IDX_W-1:0]          found_index;
    logic                      found;
    logic                      bad_shift;

    // mirror of the block's state
    logic [STATE_W-1:0] state_mirror [TABLE_DEPTH];
    logic [ORDER_W-1:0] order_mirror;
    search_result_t     pending_searches [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int quiet_cycles   = 0;
    int n_loads        = 0;
    int n_queries      = 0;
    int n_hits         = 0;
    int n_bad          = 0;
    int n_order_writes = 0;

    msequence_product_shift_search_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .load_index   (load_index),
        .load_value   (load_value),
        .shift_a      (shift_a),
        .shift_b      (shift_b),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found_index  (found_index),
        .found        (found),
        .bad_shift    (bad_shift)
    );

    always #10 clk = ~clk;

    // register length actually used by the block
    function automatic int effective_order(input logic [ORDER_W-1:0] n);
        if (n < 1)
            return 1;
        if (n > MAX_ORDER_DEF)
            return MAX_ORDER_DEF;
        return int'(n);
    endfunction

    // wrap both shifts, XOR their states, keep the last matching entry
    function automatic search_result_t predict_search(input logic signed [SHIFT_W-1:0] sa,
                                                      input logic signed [SHIFT_W-1:0] sb);
        search_result_t     r;
        int                 len;
        int                 pa;
        int                 pb;
        logic [STATE_W-1:0] target;
        r.index = '0;
        r.hit   = 1'b0;
        r.bad   = 1'b0;
        len = 1 << effective_order(order_mirror);
        pa  = int'(sa);
        pb  = int'(sb);
        if (pa < 0)
            pa += len - 1;
        if (pb < 0)
            pb += len - 1;
        if (pa < 0 || pa >= len || pb < 0 || pb >= len)
            r.bad = 1'b1;
        else
        begin
            target = state_mirror[pa] ^ state_mirror[pb];
            for (int i = 0; i < len; i++)
            begin
                if (state_mirror[i] == target)
                begin
                    r.hit   = 1'b1;
                    r.index = IDX_W'(i);
                end
            end
        end
        return r;
    endfunction

    // present one word, hold it until taken, then update the mirror
    task automatic send_item(input logic m, input logic [IDX_W-1:0] li,
                             input logic [STATE_W-1:0] lv, input int sa, input int sb);
        search_result_t r;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        mode       <= m;
        load_index <= li;
        load_value <= lv;
        shift_a    <= sa[SHIFT_W-1:0];
        shift_b    <= sb[SHIFT_W-1:0];
        do
            @(posedge clk);
        while (item_stall);
        if (m == MODE_LOAD)
        begin
            state_mirror[li] = lv;
            n_loads++;
        end
        else
        begin
            r = predict_search(sa[SHIFT_W-1:0], sb[SHIFT_W-1:0]);
            pending_searches.push_back(r);
            n_queries++;
            if (r.hit)
                n_hits++;
            if (r.bad)
                n_bad++;
        end
    endtask

    // drop valid, wait for all search words, then let a trailing load finish
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_searches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        order_mirror = v;
        n_order_writes++;
        cfg_valid <= 1'b0;
    endtask

    // mostly in-range shifts, some just outside, some anywhere in the field
    function automatic int random_shift(input int len);
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return int'($urandom_range(0, 2 * len - 2)) - (len - 1);
        if (p < 85)
            return $urandom_range(0, 1) ? len : -len;
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    task automatic send_random_item(input int query_pct);
        int                 len;
        int                 p;
        logic [IDX_W-1:0]   li;
        logic [STATE_W-1:0] lv;
        len = 1 << effective_order(order_mirror);
        if ($urandom_range(99) < query_pct)
        begin
            li = IDX_W'($urandom);
            lv = STATE_W'($urandom);
            send_item(MODE_QUERY, li, lv, random_shift(len), random_shift(len));
        end
        else
        begin
            li = ($urandom_range(99) < 80) ? IDX_W'($urandom_range(0, len - 1))
                                           : IDX_W'($urandom);
            p  = $urandom_range(99);
            if (p < 40)
                lv = state_mirror[$urandom_range(0, len - 1)];
            else if (p < 70)
                lv = STATE_W'($urandom_range(0, 3));
            else
                lv = STATE_W'($urandom);
            send_item(MODE_LOAD, li, lv, int'($urandom_range(0, 2047)) - 1024,
                      int'($urandom_range(0, 2047)) - 1024);
        end
    endtask

    // cleared table at the reset order: every entry matches a zero target
    task automatic test_cleared_table();
        send_item(MODE_QUERY, 10'h3FF, 10'h3FF, 0, 0);
        send_item(MODE_QUERY, 10'h000, 10'h000, -1024, 5);
        send_item(MODE_QUERY, 10'h155, 10'h2AA, 1023, -1023);
    endtask

    // smallest table: two entries, wrap of -1, shifts just outside
    task automatic test_order_one();
        write_order(4'd1);
        send_item(MODE_LOAD, 10'd0, 10'h3FF, -1024, 1023);
        send_item(MODE_LOAD, 10'd1, 10'h2AA, 1023, -1024);
        send_item(MODE_QUERY, 10'd0, 10'd0, 0, 1);
        send_item(MODE_QUERY, 10'd0, 10'd0, 1, 1);
        send_item(MODE_LOAD, 10'd1, 10'h000, 0, 0);
        send_item(MODE_QUERY, 10'd0, 10'd0, 0, 1);
        send_item(MODE_QUERY, 10'd0, 10'd0, -1, -1);
        send_item(MODE_QUERY, 10'd0, 10'd0, 2, 0);
        send_item(MODE_QUERY, 10'd0, 10'd0, 0, -2);
        // entry beyond the scanned range must not be found
        send_item(MODE_LOAD, 10'h3FF, 10'h155, 0, 0);
        send_item(MODE_QUERY, 10'd0, 10'd0, 0, 0);
    endtask

    // duplicate entries: the highest index wins; then a target that is absent
    task automatic test_last_match();
        write_order(4'd2);
        send_item(MODE_LOAD, 10'd0, 10'd5, 0, 0);
        send_item(MODE_LOAD, 10'd1, 10'd3, 0, 0);
        send_item(MODE_LOAD, 10'd2, 10'd6, 0, 0);
        send_item(MODE_LOAD, 10'd3, 10'd6, 0, 0);
        send_item(MODE_QUERY, 10'd0, 10'd0, 0, 1);
        send_item(MODE_QUERY, 10'd0, 10'd0, -3, 0);
    endtask

    // order 0 acts as 1, orders above the maximum act as the maximum
    task automatic test_order_clamp();
        write_order(4'd0);
        send_item(MODE_QUERY, 10'd0, 10'd0, 1, -1);
        send_item(MODE_QUERY, 10'd0, 10'd0, 2, 0);
        write_order(4'd15);
        send_item(MODE_QUERY, 10'd0, 10'd0, 1023, -1);
    endtask

    // random traffic in three order bands under one idling setting
    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input int count);
        int                 len;
        int                 n;
        logic [STATE_W-1:0] s;
        logic [STATE_W-1:0] taps;
        logic [STATE_W-1:0] nxt;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        // small order, table loaded with a real m-sequence so sums hit
        n = $urandom_range(2, 5);
        write_order(ORDER_W'(n));
        len  = 1 << n;
        taps = (n == 5) ? 10'h005 : 10'h003;
        s    = STATE_W'($urandom_range(1, len - 1));
        for (int i = 0; i < len - 1; i++)
        begin
            send_item(MODE_LOAD, IDX_W'(i), s, 0, 0);
            nxt = (s << 1) & ((10'd1 << n) - 10'd1);
            if (s[n-1])
                nxt ^= taps;
            s = nxt;
        end
        send_item(MODE_LOAD, IDX_W'(len - 1), STATE_W'($urandom_range(0, len - 1)), 0, 0);
        repeat (count / 2 - len) send_random_item(60);
        // mid band, order 0 included
        write_order(ORDER_W'($urandom_range(0, 8)));
        repeat (count / 3) send_random_item(50);
        // full table, mostly loads since each query scans 1024 entries
        write_order(ORDER_W'($urandom_range(10, 15)));
        repeat (count - count / 2 - count / 3) send_random_item(15);
    endtask

    // receiver stall
    always @(posedge clk)
        result_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

    // compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        search_result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_searches.size() == 0)
            begin
                $error("result word with no query outstanding: found_index %0d", found_index);
                errors++;
            end
            else
            begin
                exp_r = pending_searches.pop_front();
                if (found_index !== exp_r.index)
                begin
                    $error("found_index: expected %0d, got %0d", exp_r.index, found_index);
                    errors++;
                end
                if (found !== exp_r.hit)
                begin
                    $error("found: expected %0d, got %0d", exp_r.hit, found);
                    errors++;
                end
                if (bad_shift !== exp_r.bad)
                begin
                    $error("bad_shift: expected %0d, got %0d", exp_r.bad, bad_shift);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        item_valid = 1'b0;
        mode       = MODE_LOAD;
        load_index = '0;
        load_value = '0;
        shift_a    = '0;
        shift_b    = '0;
        order_mirror = ORDER_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
            state_mirror[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_table();
        test_order_one();
        test_last_match();
        test_order_clamp();
        test_random_traffic(0, 0, 140);
        test_random_traffic(49, 0, 140);
        test_random_traffic(0, 49, 140);
        test_random_traffic(37, 37, 140);
        settle();

        $display("run covered %0d loads and %0d queries (%0d matched, %0d shifts out of range)",
                 n_loads, n_queries, n_hits, n_bad);
        $display("across %0d order writes and four idle/stall mixes, %0d mismatches",
                 n_order_writes, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
